// ===== design/fcbs_pkg.sv =====
`timescale 1ns / 1ps

package fcbs_pkg;

  // Plane registers and their APB window (one 64-bit register every 8 bytes).
  localparam int REG_COUNT  = 6;
  localparam int ADDR_BITS  = 6;
  localparam int IDX_BITS   = 3;
  localparam int DATA_BITS  = 64;
  localparam int OUT_BITS   = 8;

  localparam logic [IDX_BITS-1:0] REG_PLANE_NEAR   = 3'd0;
  localparam logic [IDX_BITS-1:0] REG_PLANE_FAR    = 3'd1;
  localparam logic [IDX_BITS-1:0] REG_PLANE_RIGHT  = 3'd2;
  localparam logic [IDX_BITS-1:0] REG_PLANE_LEFT   = 3'd3;
  localparam logic [IDX_BITS-1:0] REG_PLANE_TOP    = 3'd4;
  localparam logic [IDX_BITS-1:0] REG_PLANE_BOTTOM = 3'd5;

  // Offset d is moved to the dot-product scale by this shift.
  localparam int NORM_SHIFT = 14;

  localparam logic [1:0] VERDICT_INSIDE    = 2'd0;
  localparam logic [1:0] VERDICT_INTERSECT = 2'd1;
  localparam logic [1:0] VERDICT_OUTSIDE   = 2'd2;

  localparam logic KIND_SPHERE = 1'b0;
  localparam logic KIND_BOX    = 1'b1;

  // Normal components are Q1.14, offset is Q11.4; nx sits in the low bits.
  typedef struct packed {
    logic signed [15:0] d;
    logic signed [15:0] nz;
    logic signed [15:0] ny;
    logic signed [15:0] nx;
  } plane_t;

  typedef struct packed {
    logic far_below;
    logic near_below;
  } plane_flags_t;

endpackage

// ===== design/frustum_cull_box_sphere.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake                    Content
// s_*       in         s_tvalid / s_tready          one query (box or sphere)
// m_*       out        m_tvalid / m_tready          verdict for that query
// APB       in/out     psel, penable, pready        six 64-bit plane registers
//
// Four register stages: input capture, corner select and products, sums and
// compares for every plane at once, verdict merge into the output register.
// One query per cycle is accepted while no stall at m_tready holds the pipeline.
// Reset is synchronous and clears all valid bits and the plane registers.
// A stall at m_tready freezes every stage together, so s_tready follows it.

module frustum_cull_box_sphere #(
  parameter int PLANE_COUNT = 6,
  parameter int COORD_BITS  = 16
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      s_tvalid,
  output logic                                      s_tready,
  // lo_x, lo_y, lo_z, hi_x, hi_y, hi_z, radius, zero fill
  input  logic [((7*COORD_BITS-1)+7)/8*8-1:0]       s_tdata,
  // kind
  input  logic                                      s_tuser,
  output logic                                      m_tvalid,
  input  logic                                      m_tready,
  // verdict, zero fill
  output logic [fcbs_pkg::OUT_BITS-1:0]             m_tdata,
  input  logic                                      psel,
  input  logic                                      penable,
  input  logic                                      pwrite,
  input  logic [fcbs_pkg::ADDR_BITS-1:0]            paddr,
  input  logic [fcbs_pkg::DATA_BITS-1:0]            pwdata,
  output logic [fcbs_pkg::DATA_BITS-1:0]            prdata,
  output logic                                      pready
);
  import fcbs_pkg::*;

  localparam int CB = COORD_BITS;

  logic [DATA_BITS-1:0] planes [REG_COUNT];
  logic [IDX_BITS-1:0]  reg_idx;

  logic en;
  logic v1, v2, v3;
  logic kind1, kind2, kind3, out_kind;
  logic signed [CB-1:0] lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;
  logic [CB-2:0]        radius;
  logic [1:0]           verdict;
  logic [1:0]           verdict_next;
  logic                 any_outside, any_intersect;

  plane_flags_t flags [PLANE_COUNT];

  // Configuration port
  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_BITS-1:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        planes[i] <= '0;
      end
    end else if (psel && penable && pwrite && pready && (reg_idx < IDX_BITS'(REG_COUNT))) begin
      planes[reg_idx] <= pwdata;
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx < IDX_BITS'(REG_COUNT)) begin
      prdata = planes[reg_idx];
    end
  end

  // Pipeline control
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      v1       <= s_tvalid;
      v2       <= v1;
      v3       <= v2;
      m_tvalid <= v3;
    end
  end

  // Stage 1: capture the query
  always_ff @(posedge clk) begin
    if (en) begin
      kind1  <= s_tuser;
      lo_x   <= s_tdata[0*CB +: CB];
      lo_y   <= s_tdata[1*CB +: CB];
      lo_z   <= s_tdata[2*CB +: CB];
      hi_x   <= s_tdata[3*CB +: CB];
      hi_y   <= s_tdata[4*CB +: CB];
      hi_z   <= s_tdata[5*CB +: CB];
      radius <= s_tdata[6*CB +: CB-1];
      kind2  <= kind1;
      kind3  <= kind2;
    end
  end

  // Stages 2 and 3: one test unit per plane
  for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_plane
    plane_t plane_cur;
    if (p < REG_COUNT) begin : g_reg
      assign plane_cur = plane_t'(planes[p]);
    end else begin : g_zero
      // Planes past the register file are all zero and never cull.
      assign plane_cur = '0;
    end

    fcbs_plane #(
      .COORD_BITS(CB)
    ) u_plane (
      .clk    (clk),
      .en     (en),
      .is_box (kind1 == KIND_BOX),
      .lo_x   (lo_x),
      .lo_y   (lo_y),
      .lo_z   (lo_z),
      .hi_x   (hi_x),
      .hi_y   (hi_y),
      .hi_z   (hi_z),
      .radius (radius),
      .plane  (plane_cur),
      .flags  (flags[p])
    );
  end

  // Stage 4: merge the per-plane results
  always_comb begin
    any_outside   = 1'b0;
    any_intersect = 1'b0;
    for (int i = 0; i < PLANE_COUNT; i++) begin
      any_outside   = any_outside | flags[i].far_below;
      any_intersect = any_intersect | flags[i].near_below;
    end
    if (any_outside) begin
      verdict_next = VERDICT_OUTSIDE;
    end else if (any_intersect) begin
      verdict_next = VERDICT_INTERSECT;
    end else begin
      verdict_next = VERDICT_INSIDE;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      verdict  <= verdict_next;
      out_kind <= kind3;
    end
  end

  assign m_tdata = {{(OUT_BITS-2){1'b0}}, verdict};

  // Checks
  a_verdict_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (verdict == VERDICT_INSIDE || verdict == VERDICT_INTERSECT ||
                  verdict == VERDICT_OUTSIDE))
    else $error("verdict code out of range");

  a_sphere_no_intersect: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_kind == KIND_SPHERE) |-> (verdict != VERDICT_INTERSECT))
    else $error("sphere query reported as intersecting");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> (!m_tvalid && !v1 && !v2 && !v3))
    else $error("pipeline holds a request after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (v3 && !en) |=> (v3 && $stable(kind3)))
    else $error("stage three lost a request during a stall");

endmodule

// ===== design/fcbs_plane.sv =====
`timescale 1ns / 1ps

module fcbs_plane #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic                         is_box,
  input  logic signed [COORD_BITS-1:0] lo_x,
  input  logic signed [COORD_BITS-1:0] lo_y,
  input  logic signed [COORD_BITS-1:0] lo_z,
  input  logic signed [COORD_BITS-1:0] hi_x,
  input  logic signed [COORD_BITS-1:0] hi_y,
  input  logic signed [COORD_BITS-1:0] hi_z,
  input  logic        [COORD_BITS-2:0] radius,
  input  fcbs_pkg::plane_t             plane,
  output fcbs_pkg::plane_flags_t       flags
);
  import fcbs_pkg::*;

  localparam int PW = COORD_BITS + 16;
  localparam int SW = (COORD_BITS + 19 > 31) ? COORD_BITS + 19 : 31;

  logic signed [COORD_BITS-1:0] far_x, far_y, far_z;
  logic signed [COORD_BITS-1:0] near_x, near_y, near_z;

  logic signed [PW-1:0] pf_x, pf_y, pf_z;
  logic signed [PW-1:0] pn_x, pn_y, pn_z;
  logic [COORD_BITS-2:0] rad_q;
  logic signed [15:0]    d_q;
  logic                  box_q;

  logic signed [SW-1:0] rad_term, d_term, far_sum, near_sum;

  // The far corner takes hi where the normal component is non-negative.
  // A sphere uses its centre, which arrives on the lo fields.
  always_comb begin
    far_x  = (is_box && !plane.nx[15]) ? hi_x : lo_x;
    far_y  = (is_box && !plane.ny[15]) ? hi_y : lo_y;
    far_z  = (is_box && !plane.nz[15]) ? hi_z : lo_z;
    near_x = plane.nx[15] ? hi_x : lo_x;
    near_y = plane.ny[15] ? hi_y : lo_y;
    near_z = plane.nz[15] ? hi_z : lo_z;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pf_x  <= far_x * plane.nx;
      pf_y  <= far_y * plane.ny;
      pf_z  <= far_z * plane.nz;
      pn_x  <= near_x * plane.nx;
      pn_y  <= near_y * plane.ny;
      pn_z  <= near_z * plane.nz;
      rad_q <= radius;
      d_q   <= plane.d;
      box_q <= is_box;
    end
  end

  always_comb begin
    rad_term = box_q ? '0 : SW'({rad_q, {NORM_SHIFT{1'b0}}});
    d_term   = SW'($signed({d_q, {NORM_SHIFT{1'b0}}}));
    far_sum  = SW'(pf_x) + SW'(pf_y) + SW'(pf_z) + rad_term;
    near_sum = SW'(pn_x) + SW'(pn_y) + SW'(pn_z);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      flags.far_below  <= far_sum < d_term;
      flags.near_below <= box_q && (near_sum < d_term);
    end
  end

endmodule
